// File: src/etp_pkg.sv
// ----------------------------------------------------------------------------
// etp_pkg
// Shared widths, constants and handshake structs of the eased progress timer.
// ----------------------------------------------------------------------------
`default_nettype none
package etp_pkg;

    localparam int FRACTION_BITS = 16;
    localparam int TIME_BITS     = 24;

    localparam int ONE_W   = FRACTION_BITS + 1;
    localparam int CMD_W   = 2;
    localparam int DELTA_W = 16;
    localparam int CFG_W   = 24;
    localparam int IDX_W   = 2;
    localparam int PCT_W   = 7;

    localparam logic [ONE_W-1:0] ONE = ONE_W'(1) << FRACTION_BITS;

    // 10000 * q^2 numerator of the ramps
    localparam int K_W = 14;
    localparam logic [K_W-1:0] K_EASE = K_W'(10000);
    localparam int SQ_W = 2 * ONE_W;
    localparam int KN_W = SQ_W + K_W;
    localparam int DEN_E_W = K_W + FRACTION_BITS;

    localparam int SUM_W = ((TIME_BITS > DELTA_W) ? TIME_BITS : DELTA_W) + 1;

    localparam int NUM_W = ((TIME_BITS + FRACTION_BITS > KN_W) ?
                            (TIME_BITS + FRACTION_BITS) : KN_W) + 1;
    localparam int DEN_W = (TIME_BITS > DEN_E_W) ? TIME_BITS : DEN_E_W;
    localparam int CNT_W = $clog2(NUM_W + 1);

    typedef enum logic [CMD_W-1:0] {
        CMD_START = 2'd0,
        CMD_TICK  = 2'd1,
        CMD_STOP  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [IDX_W-1:0] {
        REG_ENABLE   = 2'd0,
        REG_DURATION = 2'd1,
        REG_EASE_IN  = 2'd2,
        REG_EASE_OUT = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic             go;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quo;
    } t_div_rsp;

endpackage
`default_nettype wire

// File: src/etp_ifs.sv
// ----------------------------------------------------------------------------
// etp_ifs
// Valid/ready channels of the eased progress timer: command, result, config.
// ----------------------------------------------------------------------------
`default_nettype none
interface etp_in_if;
    logic                        valid;
    logic                        ready;
    logic [etp_pkg::CMD_W-1:0]   cmd;
    logic [etp_pkg::DELTA_W-1:0] delta_time;
    modport source (output valid, cmd, delta_time, input ready);
    modport sink   (input valid, cmd, delta_time, output ready);
endinterface

interface etp_out_if;
    logic                      valid;
    logic                      ready;
    logic [etp_pkg::ONE_W-1:0] linear_progress;
    logic [etp_pkg::ONE_W-1:0] eased_value;
    logic                      done_res;
    modport source (output valid, linear_progress, eased_value, done_res, input ready);
    modport sink   (input valid, linear_progress, eased_value, done_res, output ready);
endinterface

interface etp_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [etp_pkg::IDX_W-1:0] index;
    logic [etp_pkg::CFG_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: src/etp_div.sv
// ----------------------------------------------------------------------------
// etp_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module etp_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire etp_pkg::t_div_req i_req,
    output etp_pkg::t_div_rsp      o_rsp
);
    localparam int NW = etp_pkg::NUM_W;
    localparam int DW = etp_pkg::DEN_W;
    localparam int CW = etp_pkg::CNT_W;

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [NW-1:0] r_quo;

    logic [DW:0]   trial;
    logic          fits;
    logic [DW:0]   diff;

    always_comb begin
        trial = {r_rem, r_quo[NW-1]};
        fits  = trial >= {1'b0, r_den};
        diff  = trial - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.go) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
                r_rem  <= '0;
                r_quo  <= i_req.num;
                r_den  <= i_req.den;
            end else if (r_busy) begin
                r_rem <= fits ? diff[DW-1:0] : trial[DW-1:0];
                r_quo <= {r_quo[NW-2:0], fits};
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
endmodule
`default_nettype wire

// File: src/eased_transition_progress.sv
// ----------------------------------------------------------------------------
// eased_transition_progress
// Eased transition timer: elapsed time, linear and eased progress, done flag.
// ----------------------------------------------------------------------------
// A start item clears elapsed time and arms the timer; a tick item advances it
// and returns linear progress elapsed/duration in Q1.16 plus the eased value;
// a stop item on a running timer returns full progress with done. A tick
// uses up to two passes of the bit-serial divider, one for elapsed/duration
// (skipped when the tick reaches the duration) and one for the ease curve
// (skipped where the curve is zero), with the multiply states S_MUL_SQ and
// S_MUL_K between them on a ramp. The divider produces one quotient bit per
// cycle. A result waiting on the output does not hold off the next item;
// only the next result waits for the output register.
`default_nettype none
module eased_transition_progress (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    etp_in_if.sink     i_in,
    etp_out_if.source  o_out,
    etp_cfg_if.sink    i_cfg
);
    localparam int FB     = etp_pkg::FRACTION_BITS;
    localparam int TB     = etp_pkg::TIME_BITS;
    localparam int OW     = etp_pkg::ONE_W;
    localparam int NW     = etp_pkg::NUM_W;
    localparam int DW     = etp_pkg::DEN_W;
    localparam int SW     = etp_pkg::SUM_W;
    localparam int EW     = etp_pkg::DEN_E_W;
    localparam int QW     = etp_pkg::SQ_W;
    localparam int KW     = etp_pkg::KN_W;
    localparam int PW     = etp_pkg::PCT_W;
    localparam int P100_W = OW + 7;
    localparam int P200_W = OW + 8;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_DIV_P  = 7'b0000010,
        S_SELECT = 7'b0000100,
        S_MUL_SQ = 7'b0001000,
        S_MUL_K  = 7'b0010000,
        S_DIV_E  = 7'b0100000,
        S_OUT    = 7'b1000000
    } t_state;

    t_state r_state;

    logic          r_enable;
    logic [TB-1:0] r_duration;
    logic [PW-1:0] r_ease_in;
    logic [PW-1:0] r_ease_out;

    logic          r_running;
    logic [TB-1:0] r_elapsed;

    logic [OW-1:0] r_p;
    logic [OW-1:0] r_res;
    logic          r_fin;
    logic          r_mode_out;
    logic [OW-1:0] r_q;
    logic [EW-1:0] r_den_e;
    logic [QW-1:0] r_sq;

    logic          r_out_valid;
    logic [OW-1:0] r_out_lin;
    logic [OW-1:0] r_out_eased;
    logic          r_out_done;

    etp_pkg::t_div_req r_div;
    etp_pkg::t_div_rsp div_rsp;

    etp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_div),
        .o_rsp   (div_rsp)
    );

    // tick arithmetic
    logic [SW-1:0] sum;
    logic [TB-1:0] e_new;
    logic          tick_full;

    // ease curve selection
    logic [5:0]        a_pct;
    logic [5:0]        b_pct;
    logic [7:0]        d_span;
    logic [13:0]       ad;
    logic [13:0]       bd;
    logic [P100_W-1:0] p100;
    logic              in_ramp;
    logic              out_ramp;
    logic [P200_W-1:0] p200;
    logic [P200_W-1:0] a_one;
    logic [NW-1:0]     ease_num;
    logic [NW-1:0]     mid_num;
    logic [OW-1:0]     ease_res;

    // divider start and output load
    logic              n_div_go;
    logic              out_load;

    always_comb begin
        sum       = SW'(r_elapsed) + SW'(i_in.delta_time);
        e_new     = (sum > SW'(r_duration)) ? r_duration : sum[TB-1:0];
        tick_full = (r_duration == '0) || (e_new >= r_duration);

        a_pct  = (r_ease_in  > PW'(50)) ? 6'd50 : r_ease_in[5:0];
        b_pct  = (r_ease_out > PW'(50)) ? 6'd50 : r_ease_out[5:0];
        d_span = 8'd200 - 8'(a_pct) - 8'(b_pct);
        ad     = 14'(a_pct) * 14'(d_span);
        bd     = 14'(b_pct) * 14'(d_span);

        p100     = P100_W'(r_p) * P100_W'(100);
        in_ramp  = (a_pct != '0) && (p100 < P100_W'({a_pct, {FB{1'b0}}}));
        out_ramp = (b_pct != '0) &&
                   (p100 > P100_W'({7'(7'd100 - 7'(b_pct)), {FB{1'b0}}}));
        p200     = P200_W'(r_p) * P200_W'(200);
        a_one    = P200_W'({a_pct, {FB{1'b0}}});
        mid_num  = NW'(p200 - a_one) + NW'(d_span >> 1);
        ease_num = NW'(KW'(r_sq) * KW'(etp_pkg::K_EASE)) + NW'(r_den_e >> 1);

        if (r_mode_out) begin
            ease_res = (div_rsp.quo > NW'(etp_pkg::ONE)) ? '0 :
                       etp_pkg::ONE - div_rsp.quo[OW-1:0];
        end else begin
            ease_res = (div_rsp.quo > NW'(etp_pkg::ONE)) ? etp_pkg::ONE :
                       div_rsp.quo[OW-1:0];
        end

        n_div_go = 1'b0;
        if ((r_state == S_IDLE) && i_in.valid && r_running && !tick_full &&
            (etp_pkg::t_cmd'(i_in.cmd) == etp_pkg::CMD_TICK)) begin
            n_div_go = 1'b1;
        end
        if ((r_state == S_SELECT) && !in_ramp && !out_ramp && (p200 > a_one)) begin
            n_div_go = 1'b1;
        end
        if (r_state == S_MUL_K) begin
            n_div_go = 1'b1;
        end

        out_load = (r_state == S_OUT) && (!r_out_valid || o_out.ready);
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable   <= 1'b1;
            r_duration <= '0;
            r_ease_in  <= '0;
            r_ease_out <= '0;
        end else if (i_cfg.valid) begin
            unique case (etp_pkg::t_reg_idx'(i_cfg.index))
                etp_pkg::REG_ENABLE:   r_enable   <= i_cfg.data[0];
                etp_pkg::REG_DURATION: r_duration <= TB'(i_cfg.data);
                etp_pkg::REG_EASE_IN:  r_ease_in  <= i_cfg.data[PW-1:0];
                etp_pkg::REG_EASE_OUT: r_ease_out <= i_cfg.data[PW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_running   <= 1'b0;
            r_elapsed   <= '0;
            r_out_valid <= 1'b0;
            r_div.go    <= 1'b0;
        end else begin
            r_div.go <= n_div_go;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        case (etp_pkg::t_cmd'(i_in.cmd))
                            etp_pkg::CMD_START: begin
                                r_running <= r_enable && (r_duration != '0);
                                r_elapsed <= '0;
                            end
                            etp_pkg::CMD_STOP: begin
                                if (r_running) begin
                                    r_running <= 1'b0;
                                    r_elapsed <= '0;
                                    r_p       <= etp_pkg::ONE;
                                    r_res     <= etp_pkg::ONE;
                                    r_fin     <= 1'b1;
                                    r_state   <= S_OUT;
                                end
                            end
                            etp_pkg::CMD_TICK: begin
                                if (r_running) begin
                                    if (tick_full) begin
                                        r_running <= 1'b0;
                                        r_elapsed <= '0;
                                        r_p       <= etp_pkg::ONE;
                                        r_fin     <= 1'b1;
                                        r_state   <= S_SELECT;
                                    end else begin
                                        r_elapsed <= e_new;
                                        r_fin     <= 1'b0;
                                        r_div.num <= NW'({e_new, {FB{1'b0}}});
                                        r_div.den <= DW'(r_duration);
                                        r_state   <= S_DIV_P;
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_DIV_P: begin
                    if (div_rsp.done) begin
                        r_p     <= div_rsp.quo[OW-1:0];
                        r_state <= S_SELECT;
                    end
                end
                S_SELECT: begin
                    if (in_ramp) begin
                        r_mode_out <= 1'b0;
                        r_q        <= r_p;
                        r_den_e    <= {ad, {FB{1'b0}}};
                        r_state    <= S_MUL_SQ;
                    end else if (out_ramp) begin
                        r_mode_out <= 1'b1;
                        r_q        <= etp_pkg::ONE - r_p;
                        r_den_e    <= {bd, {FB{1'b0}}};
                        r_state    <= S_MUL_SQ;
                    end else if (p200 > a_one) begin
                        r_mode_out <= 1'b0;
                        r_div.num  <= mid_num;
                        r_div.den  <= DW'(d_span);
                        r_state    <= S_DIV_E;
                    end else begin
                        r_res   <= '0;
                        r_state <= S_OUT;
                    end
                end
                S_MUL_SQ: begin
                    r_sq    <= QW'(r_q) * QW'(r_q);
                    r_state <= S_MUL_K;
                end
                S_MUL_K: begin
                    r_div.num <= ease_num;
                    r_div.den <= DW'(r_den_e);
                    r_state   <= S_DIV_E;
                end
                S_DIV_E: begin
                    if (div_rsp.done) begin
                        r_res   <= ease_res;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        r_out_lin   <= r_p;
                        r_out_eased <= r_res;
                        r_out_done  <= r_fin;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready            = (r_state == S_IDLE);
    assign i_cfg.ready           = 1'b1;
    assign o_out.valid           = r_out_valid;
    assign o_out.linear_progress = r_out_lin;
    assign o_out.eased_value     = r_out_eased;
    assign o_out.done_res        = r_out_done;
endmodule
`default_nettype wire

// File: verif/etp_tb_ifs.sv
// ----------------------------------------------------------------------------
// etp_tb_ifs
// Testbench item types of the eased progress timer: result and command items.
// ----------------------------------------------------------------------------
// the block's own interface file is used as is; this file only holds the
// result and command item structs used by the testbench
`default_nettype none
package etp_tb_pkg;
    import etp_pkg::*;

    typedef struct packed {
        logic [ONE_W-1:0] linear;
        logic [ONE_W-1:0] eased;
        logic             done;
    } t_progress;

    typedef struct packed {
        t_cmd               cmd;
        logic [DELTA_W-1:0] delta;
    } t_cmd_item;
endpackage
`default_nettype wire

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Checks the eased transition timer against a predictor of progress and ease.
// ----------------------------------------------------------------------------
// Commands are queued by a stimulus process and driven at falling edges by a
// driver with random gaps; results are taken by a monitor with random stalls
// and compared with the predicted linear progress, eased progress and done.
// Registers are written only when no result is outstanding.
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import etp_pkg::*;
    import etp_tb_pkg::*;

    localparam int LIMIT = 4000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    etp_in_if  cmd_ch ();
    etp_out_if res_ch ();
    etp_cfg_if cfg_ch ();

    eased_transition_progress u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_ch.sink),
        .o_out   (res_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    always #5 i_clk = ~i_clk;

    // predictor state
    logic               pr_enable = 1'b1;
    logic [TIME_BITS-1:0] pr_duration = '0;
    logic [PCT_W-1:0]   pr_in_pct = '0;
    logic [PCT_W-1:0]   pr_out_pct = '0;
    logic               pr_running = 1'b0;
    logic [TIME_BITS-1:0] pr_elapsed = '0;

    t_cmd_item   pending_cmds[$];
    t_progress   expected_progress[$];
    int          fail_count = 0;
    int          cycle_count = 0;
    bit          quiet_gaps = 1'b0;
    bit          quiet_stalls = 1'b0;
    bit          cfg_busy = 1'b0;
    bit          cmd_taken = 1'b0;

    function automatic logic [63:0] round_div(logic [63:0] num, logic [63:0] den);
        return (num + den / 2) / den;
    endfunction

    function automatic logic [ONE_W-1:0] eased_of(logic [63:0] p);
        logic [63:0] a, b, d, r, q, drop, one;
        one = 64'(ONE);
        a = (pr_in_pct > 50) ? 64'd50 : 64'(pr_in_pct);
        b = (pr_out_pct > 50) ? 64'd50 : 64'(pr_out_pct);
        d = 200 - a - b;
        if (a > 0 && 100 * p < a * one) begin
            r = round_div(10000 * p * p, a * d * one);
        end else if (b > 0 && 100 * p > (100 - b) * one) begin
            q = one - p;
            drop = round_div(10000 * q * q, b * d * one);
            r = (drop > one) ? 64'd0 : one - drop;
        end else begin
            r = (200 * p > a * one) ? round_div(200 * p - a * one, d) : 64'd0;
        end
        return ONE_W'((r > one) ? one : r);
    endfunction

    // advances the predictor by one accepted item
    task automatic predict_progress(t_cmd_item it);
        logic [63:0] sum, p;
        t_progress res;
        case (it.cmd)
            CMD_START: begin
                pr_running = pr_enable && (pr_duration != 0);
                pr_elapsed = '0;
            end
            CMD_STOP: begin
                if (pr_running) begin
                    pr_running = 1'b0;
                    pr_elapsed = '0;
                    res.linear = ONE;
                    res.eased = ONE;
                    res.done = 1'b1;
                    expected_progress.push_back(res);
                end
            end
            CMD_TICK: begin
                if (pr_running) begin
                    sum = 64'(pr_elapsed) + 64'(it.delta);
                    if (sum > 64'(pr_duration)) sum = 64'(pr_duration);
                    pr_elapsed = TIME_BITS'(sum);
                    if (pr_duration == 0 || pr_elapsed >= pr_duration) begin
                        p = 64'(ONE);
                        res.done = 1'b1;
                    end else begin
                        p = (64'(pr_elapsed) << FRACTION_BITS) / 64'(pr_duration);
                        res.done = 1'b0;
                    end
                    res.linear = ONE_W'(p);
                    res.eased = eased_of(p);
                    if (res.done) begin
                        pr_running = 1'b0;
                        pr_elapsed = '0;
                    end
                    expected_progress.push_back(res);
                end
            end
            default: ;
        endcase
    endtask

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            cmd_ch.valid <= 1'b0;
            cmd_ch.cmd <= CMD_NONE;
            cmd_ch.delta_time <= '0;
        end else if (cmd_ch.valid && !cmd_taken) begin
            // hold the item
        end else if (pending_cmds.size() > 0 && !cfg_busy &&
                     (quiet_gaps || $urandom_range(99) >= 16)) begin
            cmd_ch.valid <= 1'b1;
            cmd_ch.cmd <= pending_cmds[0].cmd;
            cmd_ch.delta_time <= pending_cmds[0].delta;
            void'(pending_cmds.pop_front());
        end else begin
            cmd_ch.valid <= 1'b0;
        end
        res_ch.ready <= quiet_stalls || ($urandom_range(99) >= 16);
    end

    // input acceptance and result monitor
    always @(posedge i_clk) begin
        t_cmd_item it;
        t_progress exp_r;
        cycle_count <= cycle_count + 1;
        cmd_taken = i_rst_n && cmd_ch.valid && cmd_ch.ready;
        if (cmd_taken) begin
            it.cmd = t_cmd'(cmd_ch.cmd);
            it.delta = cmd_ch.delta_time;
            predict_progress(it);
        end
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (expected_progress.size() == 0) begin
                $error("unexpected result: linear %0d eased %0d done %0d",
                       res_ch.linear_progress, res_ch.eased_value, res_ch.done_res);
                fail_count = fail_count + 1;
            end else begin
                exp_r = expected_progress.pop_front();
                if (res_ch.linear_progress !== exp_r.linear) begin
                    $error("linear_progress: expected %0d actual %0d",
                           exp_r.linear, res_ch.linear_progress);
                    fail_count = fail_count + 1;
                end
                if (res_ch.eased_value !== exp_r.eased) begin
                    $error("eased_value: expected %0d actual %0d",
                           exp_r.eased, res_ch.eased_value);
                    fail_count = fail_count + 1;
                end
                if (res_ch.done_res !== exp_r.done) begin
                    $error("done_res: expected %0d actual %0d",
                           exp_r.done, res_ch.done_res);
                    fail_count = fail_count + 1;
                end
            end
        end
        if (cycle_count > LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // waits until every queued item is accepted and every result has come
    task automatic drain();
        while (pending_cmds.size() > 0 || cmd_ch.valid) @(posedge i_clk);
        while (expected_progress.size() > 0) @(posedge i_clk);
        // a start or ignored item may still be in flight
        repeat (150) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [CFG_W-1:0] value);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        case (idx)
            REG_ENABLE:   pr_enable = value[0];
            REG_DURATION: pr_duration = TIME_BITS'(value);
            REG_EASE_IN:  pr_in_pct = value[PCT_W-1:0];
            default:      pr_out_pct = value[PCT_W-1:0];
        endcase
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic set_cfg(logic en, logic [CFG_W-1:0] dur, int ein, int eout);
        drain();
        cfg_busy = 1'b1;
        write_reg(REG_ENABLE, CFG_W'(en));
        write_reg(REG_DURATION, dur);
        write_reg(REG_EASE_IN, CFG_W'(ein));
        write_reg(REG_EASE_OUT, CFG_W'(eout));
        cfg_busy = 1'b0;
    endtask

    task automatic push_cmd(t_cmd c, logic [DELTA_W-1:0] d);
        t_cmd_item it;
        it.cmd = c;
        it.delta = d;
        pending_cmds.push_back(it);
    endtask

    // a start followed by mostly ticks, sized so the run lasts 2 to 40 steps
    task automatic push_run(logic [CFG_W-1:0] dur);
        int steps;
        logic [31:0] span;
        steps = $urandom_range(40, 2);
        span = (dur / steps) + 1;
        if (span > 65535) span = 65535;
        push_cmd(CMD_START, DELTA_W'($urandom));
        for (int k = 0; k < steps + 2; k++) begin
            case ($urandom_range(19))
                0: push_cmd(CMD_STOP, DELTA_W'($urandom));
                1: push_cmd(CMD_NONE, DELTA_W'($urandom));
                2: push_cmd(CMD_START, DELTA_W'($urandom));
                3: push_cmd(CMD_TICK, DELTA_W'($urandom));
                default: push_cmd(CMD_TICK, DELTA_W'($urandom_range(span, 0)));
            endcase
        end
    endtask

    initial begin
        logic [CFG_W-1:0] dur;
        int total;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_ENABLE;
        cfg_ch.data = '0;
        cfg_busy = 1'b1;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        cfg_busy = 1'b0;

        // idle and zero duration: nothing armed
        push_cmd(CMD_TICK, 16'd5);
        push_cmd(CMD_STOP, 16'd0);
        push_cmd(CMD_START, 16'hFFFF);
        push_cmd(CMD_TICK, 16'hFFFF);
        set_cfg(1'b1, 24'd1000, 100, 100);
        push_cmd(CMD_START, 16'd0);
        push_cmd(CMD_TICK, 16'd0);
        push_cmd(CMD_TICK, 16'd1);
        push_cmd(CMD_TICK, 16'd250);
        push_cmd(CMD_NONE, 16'd7);
        push_cmd(CMD_TICK, 16'd500);
        push_cmd(CMD_START, 16'd0);
        push_cmd(CMD_TICK, 16'd999);
        push_cmd(CMD_TICK, 16'hFFFF);
        push_cmd(CMD_START, 16'd0);
        push_cmd(CMD_TICK, 16'd300);
        push_cmd(CMD_STOP, 16'd0);
        push_cmd(CMD_START, 16'd0);
        push_cmd(CMD_TICK, 16'd300);
        // sender holds off until all results are back
        drain();
        // lowered duration mid run, then zeroed duration after the run ends
        set_cfg(1'b1, 24'd200, 0, 30);
        push_cmd(CMD_TICK, 16'd10);
        drain();
        set_cfg(1'b1, 24'd0, 0, 30);
        push_cmd(CMD_TICK, 16'd0);
        set_cfg(1'b0, 24'hFFFFFF, 25, 0);
        push_cmd(CMD_START, 16'd0);
        push_cmd(CMD_TICK, 16'hFFFF);

        total = 0;
        while (total < 1700) begin
            int ph;
            ph = $urandom_range(7);
            quiet_gaps = (ph == 3);
            quiet_stalls = (ph == 3);
            case (ph)
                0: dur = 24'hFFFFFF;
                1: dur = 24'd1;
                2: dur = 24'($urandom_range(100, 2));
                default: dur = 24'($urandom);
            endcase
            set_cfg(($urandom_range(9) != 0), dur,
                    (ph == 0) ? 127 : $urandom_range(100),
                    (ph == 1) ? 0 : $urandom_range(100));
            for (int r = 0; r < 6; r++) begin
                push_run(dur);
            end
            total += pending_cmds.size();
            drain();
        end
        quiet_gaps = 1'b0;
        quiet_stalls = 1'b0;
        drain();
        if (fail_count == 0 && expected_progress.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
`default_nettype wire
